>>> hdl/button_debounce_long_press_repeat_defines.svh
// Assertion macros shared by the button debouncer RTL.
// Used by the front sequencer and the event queue; needs clk and arst_n in scope.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BDLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BDLP_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);
`else
`define BDLP_ASSERT(lbl, prop, msg)
`define BDLP_ASSERT_HOLD(lbl, cond, sig, msg)
`endif
`endif

>>> hdl/bdlp_pkg.sv
// Shared types and constants of the button debouncer.
// No dependencies; used by every module of the block.
package bdlp_pkg;

	localparam int MAX_BUTTONS  = 16;
	localparam int DEF_BUTTONS  = 5;
	localparam int DEF_QUEUE    = 4;
	localparam int FIELD_BUTTONS = 5;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int BTN_W     = 3;
	localparam int EV_W      = 2;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 8;

	localparam logic [CFG_W-1:0]         RST_DEBOUNCE     = 16'd20;
	localparam logic [CFG_W-1:0]         RST_LONG_PRESS   = 16'd550;
	localparam logic [CFG_W-1:0]         RST_REPEAT_DELAY = 16'd300;
	localparam logic [CFG_W-1:0]         RST_REPEAT_RATE  = 16'd80;
	localparam logic [FIELD_BUTTONS-1:0] RST_REPEAT_MASK  = 5'd15;

	typedef enum logic [EV_W-1:0] {
		EV_PRESSED  = 2'd0,
		EV_CLICKED  = 2'd1,
		EV_RELEASED = 2'd2,
		EV_LONG     = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_REPEAT_DELAY = 3'd2,
		REG_REPEAT_RATE  = 3'd3,
		REG_REPEAT_MASK  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_EVAL,
		F_EMIT,
		F_FLUSH
	} front_state_t;

	typedef struct packed {
		logic [BTN_W-1:0] button;
		event_t           ev;
		logic             last;
	} evt_t;

endpackage

>>> hdl/bdlp_fifo.sv
// Short event queue between the front sequencer and the output stage.
// Depends on bdlp_pkg for the event record type.
`include "button_debounce_long_press_repeat_defines.svh"
module bdlp_fifo #(
	parameter int DEPTH = bdlp_pkg::DEF_QUEUE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bdlp_pkg::evt_t    wdata,
	output logic              full,
	input  logic              pop,
	output bdlp_pkg::evt_t    rdata,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bdlp_pkg::evt_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`BDLP_ASSERT(a_no_overflow, push |-> !full, "event pushed into a full queue")
	`BDLP_ASSERT(a_no_underflow, pop |-> !empty, "event popped from an empty queue")
	`BDLP_ASSERT(a_count_range, cnt_q <= CW'(DEPTH), "queue fill count out of range")

endmodule

>>> hdl/bdlp_front.sv
// Front sequencer: takes samples, walks the buttons, updates their state and queues events.
// Depends on bdlp_pkg; feeds bdlp_fifo.
`include "button_debounce_long_press_repeat_defines.svh"
module bdlp_front #(
	parameter int BUTTONS = bdlp_pkg::DEF_BUTTONS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bdlp_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                 push,
	output bdlp_pkg::evt_t                       push_data,
	input  logic                                 full
);

	localparam int IW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int MB  = bdlp_pkg::MAX_BUTTONS;
	localparam int MBW = $clog2(MB);
	localparam int TW  = bdlp_pkg::TIME_W;
	localparam int FB  = bdlp_pkg::FIELD_BUTTONS;

	bdlp_pkg::front_state_t state_q, state_d;

	logic [bdlp_pkg::CFG_W-1:0] deb_q, long_q, delay_q, rate_q;
	logic [FB-1:0]              mask_q;

	logic [TW-1:0]    now_q;
	logic [FB-1:0]    raw_q;
	logic [IW-1:0]    idx_q;
	logic [1:0]       n_q;
	logic             k_q;
	bdlp_pkg::event_t ev0_q, ev1_q;
	logic             pend_valid_q;
	logic [bdlp_pkg::BTN_W-1:0] pend_btn_q;
	bdlp_pkg::event_t pend_ev_q;

	logic [BUTTONS-1:0] stable_q, prev_q, fired_q, ract_q;
	logic [TW-1:0]      dstamp_q [BUTTONS];
	logic [TW-1:0]      pstamp_q [BUTTONS];
	logic [TW-1:0]      rstamp_q [BUTTONS];

	logic [MB-1:0] raw_ext, mask_ext;
	logic          level, rep, stable, fired, ract;
	logic [TW-1:0] d_diff, h_diff, r_diff;
	logic          db_ok;
	logic [1:0]    e_n;
	bdlp_pkg::event_t e0, e1;
	logic          n_stable, n_fired, n_ract, set_p, set_r;
	logic          last_btn, take_ev, emit_done, accept, flush_done;

	assign raw_ext  = MB'(raw_q);
	assign mask_ext = MB'(mask_q);
	assign level    = raw_ext[MBW'(idx_q)];
	assign rep      = mask_ext[MBW'(idx_q)];
	assign stable   = stable_q[idx_q];
	assign fired    = fired_q[idx_q];
	assign ract     = ract_q[idx_q];
	assign d_diff   = now_q - dstamp_q[idx_q];
	assign h_diff   = now_q - pstamp_q[idx_q];
	assign r_diff   = now_q - rstamp_q[idx_q];
	// A raw change restarts the debounce window, so the difference would be zero.
	assign db_ok    = (level == prev_q[idx_q]) && (d_diff > TW'(deb_q));
	assign last_btn = (idx_q == IW'(BUTTONS - 1));

	// Events and state update of the current button.
	always_comb begin
		e_n      = 2'd0;
		e0       = bdlp_pkg::EV_PRESSED;
		e1       = bdlp_pkg::EV_PRESSED;
		n_stable = stable;
		n_fired  = fired;
		n_ract   = ract;
		set_p    = 1'b0;
		set_r    = 1'b0;
		if (db_ok) begin
			if (level != stable) begin
				n_stable = level;
				if (level) begin
					set_p   = 1'b1;
					set_r   = 1'b1;
					n_fired = 1'b0;
					n_ract  = 1'b0;
					e0      = bdlp_pkg::EV_PRESSED;
					e_n     = 2'd1;
					// Hold time is zero here, so only a zero repeat delay clicks at once.
					if (rep && (delay_q == '0)) begin
						n_ract = 1'b1;
						e1     = bdlp_pkg::EV_CLICKED;
						e_n    = 2'd2;
					end
				end else begin
					n_ract = 1'b0;
					if (!fired) begin
						e0  = bdlp_pkg::EV_CLICKED;
						e1  = bdlp_pkg::EV_RELEASED;
						e_n = 2'd2;
					end else begin
						e0  = bdlp_pkg::EV_RELEASED;
						e_n = 2'd1;
					end
				end
			end else if (stable && !fired) begin
				if (h_diff > TW'(long_q)) begin
					n_fired = 1'b1;
					e0      = bdlp_pkg::EV_LONG;
					e_n     = 2'd1;
				end else if (rep && (h_diff >= TW'(delay_q))) begin
					if (!ract) begin
						n_ract = 1'b1;
						set_r  = 1'b1;
						e0     = bdlp_pkg::EV_CLICKED;
						e_n    = 2'd1;
					end else if (r_diff >= TW'(rate_q)) begin
						set_r = 1'b1;
						e0    = bdlp_pkg::EV_CLICKED;
						e_n   = 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bdlp_pkg::F_IDLE;
		else
			state_q <= state_d;
	end

	// Each new event displaces the pending one into the queue; the pending one
	// left at the end of the sample goes out marked as last.
	always_comb begin
		state_d            = state_q;
		s_tready           = 1'b0;
		accept             = 1'b0;
		push               = 1'b0;
		take_ev            = 1'b0;
		flush_done         = 1'b0;
		emit_done          = (k_q == 1'b1) || (n_q == 2'd1);
		push_data.button   = pend_btn_q;
		push_data.ev       = pend_ev_q;
		push_data.last     = 1'b0;
		case (state_q)
			bdlp_pkg::F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = bdlp_pkg::F_EVAL;
				end
			end
			bdlp_pkg::F_EVAL: begin
				if (e_n != 2'd0)
					state_d = bdlp_pkg::F_EMIT;
				else if (last_btn)
					state_d = bdlp_pkg::F_FLUSH;
			end
			bdlp_pkg::F_EMIT: begin
				if (!(pend_valid_q && full)) begin
					take_ev = 1'b1;
					push    = pend_valid_q;
					if (emit_done)
						state_d = last_btn ? bdlp_pkg::F_FLUSH : bdlp_pkg::F_EVAL;
				end
			end
			bdlp_pkg::F_FLUSH: begin
				push_data.last = 1'b1;
				if (!pend_valid_q) begin
					state_d = bdlp_pkg::F_IDLE;
				end else if (!full) begin
					push       = 1'b1;
					flush_done = 1'b1;
					state_d    = bdlp_pkg::F_IDLE;
				end
			end
			default: state_d = bdlp_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= s_tdata[TW-1:0];
			raw_q <= s_tdata[TW+FB-1:TW];
		end
		if (state_q == bdlp_pkg::F_EVAL) begin
			ev0_q <= e0;
			ev1_q <= e1;
		end
		if (take_ev) begin
			pend_btn_q <= bdlp_pkg::BTN_W'(idx_q);
			pend_ev_q  <= k_q ? ev1_q : ev0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q        <= bdlp_pkg::RST_DEBOUNCE;
			long_q       <= bdlp_pkg::RST_LONG_PRESS;
			delay_q      <= bdlp_pkg::RST_REPEAT_DELAY;
			rate_q       <= bdlp_pkg::RST_REPEAT_RATE;
			mask_q       <= bdlp_pkg::RST_REPEAT_MASK;
			idx_q        <= '0;
			n_q          <= '0;
			k_q          <= 1'b0;
			pend_valid_q <= 1'b0;
			stable_q     <= '0;
			prev_q       <= '0;
			fired_q      <= '0;
			ract_q       <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				dstamp_q[i] <= '0;
				pstamp_q[i] <= '0;
				rstamp_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (bdlp_pkg::reg_idx_t'(cfg_index))
					bdlp_pkg::REG_DEBOUNCE:     deb_q   <= cfg_wdata;
					bdlp_pkg::REG_LONG_PRESS:   long_q  <= cfg_wdata;
					bdlp_pkg::REG_REPEAT_DELAY: delay_q <= cfg_wdata;
					bdlp_pkg::REG_REPEAT_RATE:  rate_q  <= cfg_wdata;
					bdlp_pkg::REG_REPEAT_MASK:  mask_q  <= cfg_wdata[FB-1:0];
					default: ;
				endcase
			end
			if (accept)
				idx_q <= '0;
			if (state_q == bdlp_pkg::F_EVAL) begin
				n_q              <= e_n;
				k_q              <= 1'b0;
				prev_q[idx_q]    <= level;
				stable_q[idx_q]  <= n_stable;
				fired_q[idx_q]   <= n_fired;
				ract_q[idx_q]    <= n_ract;
				if (level != prev_q[idx_q])
					dstamp_q[idx_q] <= now_q;
				if (set_p)
					pstamp_q[idx_q] <= now_q;
				if (set_r)
					rstamp_q[idx_q] <= now_q;
				if (e_n == 2'd0 && !last_btn)
					idx_q <= idx_q + 1'b1;
			end
			if (take_ev) begin
				pend_valid_q <= 1'b1;
				k_q          <= 1'b1;
				if (emit_done && !last_btn)
					idx_q <= idx_q + 1'b1;
			end
			if (flush_done)
				pend_valid_q <= 1'b0;
		end
	end

	`BDLP_ASSERT(a_idle_clean, (state_q == bdlp_pkg::F_IDLE) |-> !pend_valid_q, "pending event left over after a sample")
	`BDLP_ASSERT(a_emit_has_events, (state_q == bdlp_pkg::F_EMIT) |-> (n_q != 2'd0), "emitting for a button without events")
	`BDLP_ASSERT(a_push_not_full, push |-> !full, "front pushed into a full queue")
	`BDLP_ASSERT_HOLD(a_pending_holds, (state_q == bdlp_pkg::F_EMIT) && pend_valid_q && full, {pend_btn_q, pend_ev_q}, "pending event changed while stalled")

endmodule

>>> hdl/bdlp_out.sv
// Output stage: takes events from the queue into the result register.
// Depends on bdlp_pkg; drains bdlp_fifo.
module bdlp_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               empty,
	input  bdlp_pkg::evt_t                     rdata,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bdlp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [bdlp_pkg::EV_W-1:0]          m_tuser,
	output logic                               m_tlast
);

	logic                        valid_q;
	logic [bdlp_pkg::BTN_W-1:0]  button_q;
	bdlp_pkg::event_t            ev_q;
	logic                        last_q;

	// Load a new request whenever the register is empty or being drained.
	assign pop      = !empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = bdlp_pkg::OUT_DATA_W'(button_q);
	assign m_tuser  = ev_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			button_q <= rdata.button;
			ev_q     <= rdata.ev;
			last_q   <= rdata.last;
		end
	end

endmodule

>>> hdl/button_debounce_long_press_repeat.sv
// Button debouncer with click, long-press and auto-repeat events (top level).
// Instantiates bdlp_front, bdlp_fifo and bdlp_out; depends on bdlp_pkg.
//
// Each input request is one sample: now_ms and one raw pressed bit per button.
// The front sequencer takes a sample in F_IDLE, then evaluates each button in
// F_EVAL, emits each event produced in F_EMIT and closes the sample in
// F_FLUSH; the walk over the buttons and the events set how long a sample
// occupies it, and it stalls while a full queue meets output back-pressure.
// Events go through a small queue to the output register, so the next sample
// is taken while earlier events still wait at the output. A sample that
// changes nothing produces no output request; otherwise the final event of the
// sample carries tlast. Registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. Unknown indexes are ignored.
module button_debounce_long_press_repeat #(
	parameter int BUTTONS     = bdlp_pkg::DEF_BUTTONS,
	parameter int QUEUE_DEPTH = bdlp_pkg::DEF_QUEUE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] now_ms, [36:32] raw_pressed, [39:37] zero
	input  logic [bdlp_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] button, [7:3] zero
	output logic [bdlp_pkg::OUT_DATA_W-1:0]    m_tdata,
	// [1:0] event_res
	output logic [bdlp_pkg::EV_W-1:0]          m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]         cfg_wdata
);

	logic           push, full, pop, empty;
	bdlp_pkg::evt_t push_data, rdata;

	bdlp_front #(
		.BUTTONS (BUTTONS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	bdlp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	bdlp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.rdata    (rdata),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_long_press_repeat: timestamped button
// samples in, predicted press/click/release/long-press events checked on the way out.
// Depends on bdlp_pkg and the RTL of the block; reads no files.
module tb;
	import bdlp_pkg::*;

	localparam int NUM_BTN      = DEF_BUTTONS;
	localparam int DRAIN_CYCLES = 48;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int MAX_REPORTS  = 30;
	// An index past the register file; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;     // [31:0] now_ms, [36:32] raw_pressed, [39:37] zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [2:0] button, [7:3] zero
	logic [EV_W-1:0]      m_tuser;          // [1:0] event_res
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Predictor copy of the timing registers.
	logic [CFG_W-1:0]         debounce_len = RST_DEBOUNCE;
	logic [CFG_W-1:0]         long_len     = RST_LONG_PRESS;
	logic [CFG_W-1:0]         rep_delay    = RST_REPEAT_DELAY;
	logic [CFG_W-1:0]         rep_rate     = RST_REPEAT_RATE;
	logic [FIELD_BUTTONS-1:0] rep_mask     = RST_REPEAT_MASK;

	// Predictor copy of the per-button state.
	logic        btn_stable    [NUM_BTN];
	logic        btn_prev_raw  [NUM_BTN];
	logic [31:0] btn_bounce_t  [NUM_BTN];
	logic [31:0] btn_press_t   [NUM_BTN];
	logic        btn_long_done [NUM_BTN];
	logic        btn_rep_on    [NUM_BTN];
	logic [31:0] btn_rep_t     [NUM_BTN];

	evt_t        pending_events[$];
	logic [31:0] sample_now = '0;
	logic [4:0]  held_level = '0;
	int          step_max = 3;
	int          flip_div = 10;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int          stall_left = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	button_debounce_long_press_repeat u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic evt_t make_evt(input int b, input event_t e);
		evt_t rec;
		rec.button = BTN_W'(b);
		rec.ev     = e;
		rec.last   = 1'b0;
		return rec;
	endfunction

	// Walks the buttons for one accepted sample and queues the events it causes.
	function automatic void predict_sample(input logic [31:0] now, input logic [4:0] raw);
		logic        level;
		logic        repeats;
		logic [31:0] since;
		int          n_found;
		evt_t        rec;
		n_found = 0;
		for (int b = 0; b < NUM_BTN; b++) begin
			level   = raw[b];
			repeats = rep_mask[b];
			if (level != btn_prev_raw[b])
				btn_bounce_t[b] = now;
			since = now - btn_bounce_t[b];
			if (since > {16'd0, debounce_len}) begin
				if (level != btn_stable[b]) begin
					btn_stable[b] = level;
					if (level) begin
						btn_press_t[b]   = now;
						btn_long_done[b] = 1'b0;
						btn_rep_on[b]    = 1'b0;
						btn_rep_t[b]     = now;
						pending_events.push_back(make_evt(b, EV_PRESSED));
						n_found++;
					end else begin
						btn_rep_on[b] = 1'b0;
						if (!btn_long_done[b]) begin
							pending_events.push_back(make_evt(b, EV_CLICKED));
							n_found++;
						end
						pending_events.push_back(make_evt(b, EV_RELEASED));
						n_found++;
					end
				end
				since = now - btn_press_t[b];
				if (btn_stable[b] && !btn_long_done[b] && since > {16'd0, long_len}) begin
					btn_long_done[b] = 1'b1;
					pending_events.push_back(make_evt(b, EV_LONG));
					n_found++;
				end
				if (btn_stable[b] && repeats && !btn_long_done[b] &&
					since >= {16'd0, rep_delay}) begin
					if (!btn_rep_on[b]) begin
						btn_rep_on[b] = 1'b1;
						btn_rep_t[b]  = now;
						pending_events.push_back(make_evt(b, EV_CLICKED));
						n_found++;
					end else begin
						since = now - btn_rep_t[b];
						if (since >= {16'd0, rep_rate}) begin
							btn_rep_t[b] = now;
							pending_events.push_back(make_evt(b, EV_CLICKED));
							n_found++;
						end
					end
				end
			end
			btn_prev_raw[b] = level;
		end
		if (n_found > 0) begin
			rec = pending_events.pop_back();
			rec.last = 1'b1;
			pending_events.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin : event_check
		evt_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: unexpected event, actual button %0d event %0d last %0b",
						$time, m_tdata[BTN_W-1:0], m_tuser, m_tlast);
				error_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[BTN_W-1:0] !== want.button || m_tuser !== want.ev ||
					m_tlast !== want.last) begin
					// Fields are shown as button/event/last.
					if (error_count < MAX_REPORTS)
						$display("%0t: mismatch, expected %0d/%0d/%0b, actual %0d/%0d/%0b",
							$time, want.button, want.ev, want.last,
							m_tdata[BTN_W-1:0], m_tuser, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Output stalls only with rx_idle: mostly ready, short stalls, now and then a long one.
	always @(negedge clk) begin : rx_drive
		int r;
		r = $urandom_range(0, 99);
		if (!rx_idle) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (r < 70) begin
			m_tready <= 1'b1;
		end else begin
			stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 40);
			m_tready <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Entered and left at a falling edge; tvalid stays high between back-to-back requests.
	task automatic send_sample(input logic [31:0] now, input logic [4:0] raw);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {3'b000, raw, now};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_sample(now, raw);
		@(negedge clk);
	endtask

	// A sample with no events may still be in the walk when the queue drains,
	// hence the extra cycles.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE:     debounce_len = value;
			REG_LONG_PRESS:   long_len = value;
			REG_REPEAT_DELAY: rep_delay = value;
			REG_REPEAT_RATE:  rep_rate = value;
			REG_REPEAT_MASK:  rep_mask = value[FIELD_BUTTONS-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
		input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] rate,
		input logic [CFG_W-1:0] mask);
		settle_block();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG_PRESS, lng);
		write_reg(REG_REPEAT_DELAY, dly);
		write_reg(REG_REPEAT_RATE, rate);
		write_reg(REG_REPEAT_MASK, mask);
	endtask

	// Held levels switch now and then; single-sample glitches ride on top as bounce.
	task automatic run_random(input int count);
		logic [4:0] raw;
		repeat (count) begin
			for (int b = 0; b < NUM_BTN; b++)
				if ($urandom_range(1, flip_div) == 1)
					held_level[b] = ~held_level[b];
			raw = held_level;
			for (int b = 0; b < NUM_BTN; b++)
				if ($urandom_range(0, 15) == 0)
					raw[b] = ~raw[b];
			if ($urandom_range(0, 39) == 0)
				sample_now = $urandom();
			else
				sample_now = sample_now + $urandom_range(0, step_max);
			send_sample(sample_now, raw);
		end
	endtask

	// Reset timing: repeat clicks, long press ending them, a short press and a glitch.
	task automatic test_default_timing();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_sample(32'd100, 5'b00001);
		send_sample(32'd121, 5'b00001);
		send_sample(32'd421, 5'b00001);
		send_sample(32'd502, 5'b00001);
		send_sample(32'd600, 5'b00001);
		send_sample(32'd672, 5'b00001);
		send_sample(32'd700, 5'b00000);
		send_sample(32'd721, 5'b00000);
		send_sample(32'd800, 5'b10000);
		send_sample(32'd821, 5'b10000);
		send_sample(32'd830, 5'b00000);
		send_sample(32'd851, 5'b00000);
		send_sample(32'd900, 5'b00010);
		send_sample(32'd905, 5'b00000);
		send_sample(32'd930, 5'b00000);
	endtask

	// All buttons at once with zero debounce, delay and rate: up to ten events per sample.
	task automatic test_zero_timing();
		set_timing(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_sample(32'd2000, 5'b11111);
		send_sample(32'd2001, 5'b11111);
		send_sample(32'd2001, 5'b11111);
		send_sample(32'd2002, 5'b00000);
		send_sample(32'd2003, 5'b00000);
	endtask

	// Largest debounce across the timestamp wrap, long press at zero threshold.
	task automatic test_max_timing();
		logic [31:0] t0;
		t0 = 32'hFFFF_8000;
		set_timing(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		send_sample(t0, 5'b10101);
		send_sample(t0 + 32'd65535, 5'b10101);
		send_sample(t0 + 32'd65536, 5'b10101);
		send_sample(t0 + 32'd65537, 5'b10101);
		sample_now = t0 + 32'd65537;
		held_level = 5'b10101;
	endtask

	task automatic test_random_fast();
		set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(15, 60)),
			16'($urandom_range(0, 12)), 16'($urandom_range(0, 5)),
			16'($urandom_range(0, 31)));
		tx_idle  = 1'b1;
		rx_idle  = 1'b1;
		step_max = 3;
		flip_div = 10;
		run_random(100);
	endtask

	task automatic test_random_default();
		set_timing(RST_DEBOUNCE, RST_LONG_PRESS, RST_REPEAT_DELAY, RST_REPEAT_RATE,
			{11'd0, RST_REPEAT_MASK});
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		step_max = 40;
		flip_div = 8;
		run_random(80);
	endtask

	task automatic test_random_wide();
		set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		tx_idle  = 1'b1;
		rx_idle  = 1'b0;
		step_max = 50000;
		flip_div = 3;
		run_random(60);
	endtask

	task automatic test_random_zero();
		set_timing(16'd0, 16'($urandom_range(0, 10)), 16'd0, 16'd0, 16'd31);
		tx_idle  = 1'b1;
		rx_idle  = 1'b1;
		step_max = 2;
		flip_div = 6;
		run_random(100);
	endtask

	initial begin
		for (int b = 0; b < NUM_BTN; b++) begin
			btn_stable[b]    = 1'b0;
			btn_prev_raw[b]  = 1'b0;
			btn_bounce_t[b]  = '0;
			btn_press_t[b]   = '0;
			btn_long_done[b] = 1'b0;
			btn_rep_on[b]    = 1'b0;
			btn_rep_t[b]     = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_timing();
		test_zero_timing();
		test_max_timing();
		test_random_fast();
		test_random_default();
		test_random_wide();
		test_random_zero();

		settle_block();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
